@@ rtl/core/sm2_cipher_der_to_raw_defines.svh @@
// assertion macros shared by the sm2 der-to-raw converter
`ifndef SM2_CIPHER_DER_TO_RAW_DEFINES_SVH
`define SM2_CIPHER_DER_TO_RAW_DEFINES_SVH

// implication in the same cycle
`define SM2D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sm2d: assertion failed");

// implication on the next cycle
`define SM2D_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sm2d: assertion failed");

`endif

@@ rtl/core/sm2d_pkg.sv @@
// shared constants and command types of the sm2 der-to-raw converter
`default_nettype none

package sm2d_pkg;

	localparam int unsigned MAX_CIPHER_LEN = 65535;
	localparam int unsigned COORD_BYTES    = 32;
	localparam int unsigned HASH_BYTES     = 32;

	localparam int unsigned HASH_IDX_W = $clog2(HASH_BYTES);
	localparam int unsigned LEN_W      = 22;
	localparam logic [LEN_W-1:0] LEN_SAT    = 22'h200000;
	localparam logic [LEN_W-1:0] LEN_SAT_HI = LEN_SAT >> 8;
	localparam int unsigned REM_RAW_W  = $clog2(MAX_CIPHER_LEN + 1);
	localparam int unsigned REM_W      = (REM_RAW_W > 6) ? REM_RAW_W : 6;
	localparam int unsigned LBL_W      = 7;
	localparam int unsigned MAX_LEN_BYTES = 8;

	localparam logic [7:0] TAG_SEQ      = 8'h30;
	localparam logic [7:0] TAG_INT      = 8'h02;
	localparam logic [7:0] TAG_OCT      = 8'h04;
	localparam logic [7:0] LEN_INDEF    = 8'h80;
	localparam logic [7:0] POINT_PREFIX = 8'h04;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned APB_ADDR_W = 3;
	localparam logic        REG_ORDER  = 1'b0;

	typedef enum logic [2:0] {
		CMD_STORE,
		CMD_STORE_EMIT,
		CMD_BYTE,
		CMD_X_FIRST,
		CMD_HASH_ONE,
		CMD_FLUSH,
		CMD_BYTE_FLUSH,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            data;
		logic [HASH_IDX_W-1:0] idx;
		logic                  last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/sm2d_cmd_fifo.sv @@
// short command queue between the parser and the output engine
`default_nettype none
`include "sm2_cipher_der_to_raw_defines.svh"

module sm2d_cmd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  sm2d_pkg::cmd_t      push_cmd,
	input  wire                 pop,
	output sm2d_pkg::cmd_t      head,
	output sm2d_pkg::q_status_t status
);
	import sm2d_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);

	`SM2D_ASSERT_IMP(a_no_push_full, clk, arst_n, push, count_q != QCNT_W'(QDEPTH))
	`SM2D_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, count_q != '0)

endmodule

`default_nettype wire

@@ rtl/core/sm2d_front.sv @@
// der parser: checks tags and lengths and issues output commands
`default_nettype none

module sm2d_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          in_byte,
	input  wire                 in_last,
	input  wire                 order_cfg,
	input  sm2d_pkg::q_status_t q_status,
	output logic                push,
	output sm2d_pkg::cmd_t      push_cmd
);
	import sm2d_pkg::*;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LEN_FIRST,
		PH_LEN_SKIP,
		PH_LEN_SIG,
		PH_INT_PAD,
		PH_BODY
	} phase_t;

	typedef enum logic [2:0] {
		CTX_SEQ,
		CTX_X,
		CTX_Y,
		CTX_HASH,
		CTX_CIPH
	} ctx_t;

	phase_t                phase_q, phase_d;
	ctx_t                  ctx_q, ctx_d;
	logic [REM_W-1:0]      rem_q, rem_d;
	logic [LBL_W-1:0]      lbl_q, lbl_d, lbl_dec;
	logic [LEN_W-1:0]      acc_q, acc_d, acc_next;
	logic [HASH_IDX_W-1:0] hcnt_q, hcnt_d;
	logic                  drop_q, drop_d;
	logic                  order_q, order_d;

	logic             in_fire;
	logic             len_done;
	logic [LEN_W-1:0] len_val;
	logic             err;
	logic             done;
	logic             cmd_v;
	cmd_t             cmd;
	logic [7:0]       want;

	assign in_ready = !q_status.full;
	assign in_fire  = in_valid && in_ready;
	assign lbl_dec  = lbl_q - 1'b1;
	assign acc_next = (acc_q >= LEN_SAT_HI) ? LEN_SAT : {acc_q[LEN_W-9:0], in_byte};

	always_comb begin
		unique case (ctx_q)
			CTX_SEQ:        want = TAG_SEQ;
			CTX_X, CTX_Y:   want = TAG_INT;
			default:        want = TAG_OCT;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		ctx_d    = ctx_q;
		rem_d    = rem_q;
		lbl_d    = lbl_q;
		acc_d    = acc_q;
		hcnt_d   = hcnt_q;
		drop_d   = drop_q;
		order_d  = order_q;
		len_done = 1'b0;
		len_val  = '0;
		err      = 1'b0;
		done     = 1'b0;
		cmd_v    = 1'b0;
		cmd      = '{kind: CMD_BYTE, data: in_byte, idx: hcnt_q, last: 1'b0};

		if (drop_q) begin
			if (in_last) begin
				drop_d = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					if (in_byte != want) begin
						err = 1'b1;
					end else begin
						if (ctx_q == CTX_SEQ) begin
							order_d = order_cfg;
						end
						phase_d = PH_LEN_FIRST;
					end
				end
				PH_LEN_FIRST: begin
					if (in_byte == LEN_INDEF) begin
						len_done = 1'b1;
					end else if (in_byte[7]) begin
						lbl_d   = in_byte[6:0];
						phase_d = PH_LEN_SKIP;
					end else begin
						len_done = 1'b1;
						len_val  = LEN_W'(in_byte);
					end
				end
				PH_LEN_SKIP: begin
					if (in_byte == 8'h00) begin
						lbl_d = lbl_dec;
						if (lbl_dec == '0) begin
							len_done = 1'b1;
						end
					end else if (lbl_q > LBL_W'(MAX_LEN_BYTES)) begin
						err = 1'b1;
					end else begin
						acc_d = LEN_W'(in_byte);
						lbl_d = lbl_dec;
						if (lbl_dec == '0) begin
							len_done = 1'b1;
							len_val  = LEN_W'(in_byte);
						end else begin
							phase_d = PH_LEN_SIG;
						end
					end
				end
				PH_LEN_SIG: begin
					acc_d = acc_next;
					lbl_d = lbl_dec;
					if (lbl_dec == '0) begin
						len_done = 1'b1;
						len_val  = acc_next;
					end
				end
				PH_INT_PAD: begin
					if (in_byte != 8'h00) begin
						err = 1'b1;
					end else begin
						rem_d   = REM_W'(COORD_BYTES);
						phase_d = PH_BODY;
					end
				end
				PH_BODY: begin
					cmd_v = 1'b1;
					unique case (ctx_q)
						CTX_X, CTX_Y: begin
							if (ctx_q == CTX_X && rem_q == REM_W'(COORD_BYTES)) begin
								cmd.kind = CMD_X_FIRST;
							end
							rem_d = rem_q - 1'b1;
							if (rem_q == REM_W'(1)) begin
								ctx_d   = (ctx_q == CTX_X) ? CTX_Y : CTX_HASH;
								phase_d = PH_TAG;
							end
						end
						CTX_HASH: begin
							// in hash-first order the final hash byte waits for the cipher length
							if (order_q && hcnt_q != HASH_IDX_W'(HASH_BYTES - 1)) begin
								cmd.kind = CMD_STORE_EMIT;
							end else begin
								cmd.kind = CMD_STORE;
							end
							hcnt_d = hcnt_q + 1'b1;
							if (hcnt_q == HASH_IDX_W'(HASH_BYTES - 1)) begin
								ctx_d   = CTX_CIPH;
								phase_d = PH_TAG;
							end
						end
						default: begin
							if (!order_q && rem_q <= REM_W'(1)) begin
								cmd.kind = CMD_BYTE_FLUSH;
							end
							if (rem_q != '0) begin
								rem_d = rem_q - 1'b1;
							end
							if (rem_q <= REM_W'(1)) begin
								done = 1'b1;
							end
						end
					endcase
				end
				default: begin
					phase_d = PH_TAG;
				end
			endcase

			if (len_done) begin
				unique case (ctx_q)
					CTX_SEQ: begin
						ctx_d   = CTX_X;
						phase_d = PH_TAG;
					end
					CTX_X, CTX_Y: begin
						if (len_val == LEN_W'(COORD_BYTES)) begin
							rem_d   = REM_W'(COORD_BYTES);
							phase_d = PH_BODY;
						end else if (len_val == LEN_W'(COORD_BYTES + 1)) begin
							phase_d = PH_INT_PAD;
						end else begin
							err = 1'b1;
						end
					end
					CTX_HASH: begin
						if (len_val != LEN_W'(HASH_BYTES)) begin
							err = 1'b1;
						end else begin
							hcnt_d  = '0;
							phase_d = PH_BODY;
						end
					end
					default: begin
						if (len_val > LEN_W'(MAX_CIPHER_LEN)) begin
							err = 1'b1;
						end else begin
							rem_d   = len_val[REM_W-1:0];
							phase_d = PH_BODY;
							if (order_q) begin
								cmd_v    = 1'b1;
								cmd.kind = CMD_HASH_ONE;
							end else if (len_val == '0) begin
								cmd_v    = 1'b1;
								cmd.kind = CMD_FLUSH;
							end
							if (len_val == '0) begin
								done = 1'b1;
							end
						end
					end
				endcase
			end

			if (!err && !done && in_last) begin
				err = 1'b1;
			end

			if (err) begin
				cmd_v = 1'b1;
				cmd   = '{kind: CMD_ERR, data: 8'h00, idx: hcnt_q, last: 1'b1};
			end else if (done) begin
				cmd.last = 1'b1;
			end

			if (err || done) begin
				phase_d = PH_TAG;
				ctx_d   = CTX_SEQ;
				rem_d   = '0;
				lbl_d   = '0;
				acc_d   = '0;
				hcnt_d  = '0;
				drop_d  = !in_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			ctx_q   <= CTX_SEQ;
			rem_q   <= '0;
			lbl_q   <= '0;
			acc_q   <= '0;
			hcnt_q  <= '0;
			drop_q  <= 1'b0;
			order_q <= 1'b1;
		end else if (in_fire) begin
			phase_q <= phase_d;
			ctx_q   <= ctx_d;
			rem_q   <= rem_d;
			lbl_q   <= lbl_d;
			acc_q   <= acc_d;
			hcnt_q  <= hcnt_d;
			drop_q  <= drop_d;
			order_q <= order_d;
		end
	end

	assign push     = in_fire && cmd_v;
	assign push_cmd = cmd;

endmodule

`default_nettype wire

@@ rtl/core/sm2d_back.sv @@
// output engine: runs queued commands, owns the hash buffer and the output register
`default_nettype none
`include "sm2_cipher_der_to_raw_defines.svh"

module sm2d_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sm2d_pkg::cmd_t      head,
	input  sm2d_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic                format_error
);
	import sm2d_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SECOND,
		B_FLUSH
	} bstate_t;

	logic [7:0]            hstore [HASH_BYTES];

	bstate_t               bst_q, bst_d;
	logic [HASH_IDX_W-1:0] fcnt_q, fcnt_d;
	logic                  flast_q, flast_d;
	logic [7:0]            hold_q, hold_d;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;
	logic                  out_err_q;

	logic                  load_ok;
	logic                  ld;
	logic [7:0]            ld_byte;
	logic                  ld_last;
	logic                  ld_err;
	logic                  wr_en;
	logic [HASH_IDX_W-1:0] rd_addr;
	logic [7:0]            rd_data;

	assign load_ok = !out_valid_q || out_ready;
	assign rd_addr = (bst_q == B_FLUSH) ? fcnt_q : HASH_IDX_W'(HASH_BYTES - 1);
	assign rd_data = hstore[rd_addr];

	always_comb begin
		bst_d   = bst_q;
		fcnt_d  = fcnt_q;
		flast_d = flast_q;
		hold_d  = hold_q;
		pop     = 1'b0;
		ld      = 1'b0;
		ld_byte = head.data;
		ld_last = 1'b0;
		ld_err  = 1'b0;
		wr_en   = 1'b0;

		unique case (bst_q)
			B_IDLE: begin
				if (!q_status.empty) begin
					if (head.kind == CMD_STORE) begin
						pop   = 1'b1;
						wr_en = 1'b1;
					end else if (load_ok) begin
						pop = 1'b1;
						unique case (head.kind) inside
							CMD_STORE, CMD_STORE_EMIT: begin
								wr_en = 1'b1;
								ld    = 1'b1;
							end
							CMD_BYTE: begin
								ld      = 1'b1;
								ld_last = head.last;
							end
							CMD_X_FIRST: begin
								ld      = 1'b1;
								ld_byte = POINT_PREFIX;
								hold_d  = head.data;
								bst_d   = B_SECOND;
							end
							CMD_HASH_ONE: begin
								ld      = 1'b1;
								ld_byte = rd_data;
								ld_last = head.last;
							end
							CMD_FLUSH: begin
								fcnt_d  = '0;
								flast_d = head.last;
								bst_d   = B_FLUSH;
							end
							CMD_BYTE_FLUSH: begin
								ld      = 1'b1;
								fcnt_d  = '0;
								flast_d = head.last;
								bst_d   = B_FLUSH;
							end
							default: begin
								ld      = 1'b1;
								ld_byte = 8'h00;
								ld_last = 1'b1;
								ld_err  = 1'b1;
							end
						endcase
					end
				end
			end
			B_SECOND: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_byte = hold_q;
					bst_d   = B_IDLE;
				end
			end
			B_FLUSH: begin
				if (load_ok) begin
					ld      = 1'b1;
					ld_byte = rd_data;
					fcnt_d  = fcnt_q + 1'b1;
					if (fcnt_q == HASH_IDX_W'(HASH_BYTES - 1)) begin
						ld_last = flast_q;
						bst_d   = B_IDLE;
					end
				end
			end
			default: begin
				bst_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			hstore[head.idx] <= head.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q       <= B_IDLE;
			fcnt_q      <= '0;
			flast_q     <= 1'b0;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			bst_q       <= bst_d;
			fcnt_q      <= fcnt_d;
			flast_q     <= flast_d;
			hold_q      <= hold_d;
			out_valid_q <= ld || (out_valid_q && !out_ready);
			if (ld) begin
				out_byte_q <= ld_byte;
				out_last_q <= ld_last;
				out_err_q  <= ld_err;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;
	assign format_error = out_err_q;

	`SM2D_ASSERT_IMP(a_second_has_prefix, clk, arst_n, bst_q == B_SECOND, out_valid_q)
	`SM2D_ASSERT_IMP(a_flush_cnt_idle, clk, arst_n, bst_q != B_FLUSH, fcnt_q == '0)
	`SM2D_ASSERT_IMP(a_err_word, clk, arst_n, out_valid_q && out_err_q, out_last_q && (out_byte_q == 8'h00))

endmodule

`default_nettype wire

@@ rtl/core/sm2_cipher_der_to_raw.sv @@
// top level of the sm2 ciphertext der-to-raw converter
//
//  channel  | direction | handshake             | word
//  ---------+-----------+-----------------------+-------------------------------------
//  in       | sink      | in_valid / in_ready   | in_byte, in_last
//  out      | source    | out_valid / out_ready | out_byte, out_last, format_error
//  apb      | sink      | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// one input word is taken per cycle while the command queue has a free slot
// output runs at one word per cycle while out_ready is high; the first x byte gives two
// words, the last cipher byte in cipher-first order gives 33 and an empty cipher flush
// gives 32, so the output engine sets the sustained rate and the queue absorbs bursts
// hash-only store commands in cipher-first order need no free output slot
// arst_n clears all control state at once; the hash buffer is not cleared
// a stall on out_ready backs up the queue, then in_ready drops
`default_nettype none

module sm2_cipher_der_to_raw (
	input  wire                              clk,
	input  wire                              arst_n,
	// byte input
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [7:0]                       in_byte,
	input  wire                              in_last,
	// raw output
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [7:0]                       out_byte,
	output logic                             out_last,
	output logic                             format_error,
	// configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [sm2d_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import sm2d_pkg::*;

	// field order register, sampled by the parser at each sequence tag
	logic      hash_first_q;
	logic      reg_sel;
	logic      cfg_wr;

	// queue between parser and output engine
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_t      head;
	q_status_t q_status;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1:2] == {(APB_ADDR_W - 2){REG_ORDER}});
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_first_q <= 1'b1;
		end else if (cfg_wr) begin
			hash_first_q <= pwdata[0];
		end
	end

	// register read-back; unmapped addresses read zero
	assign prdata = reg_sel ? {31'b0, hash_first_q} : 32'b0;

	// front: tag and length decoding, one command per accepted word at most
	sm2d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.order_cfg (hash_first_q),
		.q_status  (q_status),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	sm2d_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	// back: expands commands into output words, replays the buffered hash
	sm2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_last     (out_last),
		.format_error (format_error)
	);

endmodule

`default_nettype wire
